// ===== hdl/ilp_pkg.sv =====
// shared types and constants for the integer literal parser
`timescale 1ns / 1ps
package ilp_pkg;

  localparam int unsigned IlpQueueDepth = 2;

  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 5;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned StatusW = 2;
  // result value, already whole bytes
  localparam int unsigned OutDataW = 64;
  // status and long flag
  localparam int unsigned OutUserW = 3;

  localparam logic [CharW-1:0] CharMinus  = 8'h2D;
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharNine   = 8'h39;
  localparam logic [CharW-1:0] CharUpA    = 8'h41;
  localparam logic [CharW-1:0] CharUpF    = 8'h46;
  localparam logic [CharW-1:0] CharLoA    = 8'h61;
  localparam logic [CharW-1:0] CharLoF    = 8'h66;
  localparam logic [CharW-1:0] CharUpL    = 8'h4C;
  localparam logic [CharW-1:0] CharLoL    = 8'h6C;
  localparam logic [CharW-1:0] CharX      = 8'h78;
  localparam logic [CharW-1:0] UpHexBias  = 8'h37;
  localparam logic [CharW-1:0] LoHexBias  = 8'h57;

  localparam logic [CountW-1:0] CountMax      = 5'd31;
  localparam logic [CountW-1:0] HexCap        = 5'd16;
  localparam logic [CountW-1:0] DecCap        = 5'd19;
  localparam logic [CountW-1:0] HexShortLimit = 5'd8;
  localparam logic [CountW-1:0] HexLongLimit  = 5'd16;
  localparam logic [CountW-1:0] DecShortLimit = 5'd10;
  localparam logic [CountW-1:0] DecLongLimit  = 5'd19;

  localparam logic [ValueW-1:0] MaxPosLong  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] MaxNegLong  = 64'h8000_0000_0000_0000;
  localparam logic [ValueW-1:0] MaxPosShort = 64'h0000_0000_7FFF_FFFF;
  localparam logic [ValueW-1:0] MaxNegShort = 64'h0000_0000_8000_0000;

  typedef enum logic [2:0] {
    OP_MINUS,
    OP_XCHAR,
    OP_DEC_DIGIT,
    OP_HEX_LETTER,
    OP_SUFFIX,
    OP_OTHER
  } op_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_VALID     = 2'd0,
    ST_RANGE     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  // one classified character
  typedef struct packed {
    op_kind_e   kind;
    logic [3:0] digit;
    logic       last;
  } op_t;

  // literal state at the final character
  typedef struct packed {
    logic              negative;
    logic              hex;
    logic [ValueW-1:0] magnitude;
    logic [CountW-1:0] digits;
    logic              overflow;
    logic              bad_char;
    logic              long_form;
  } rec_t;

endpackage

// ===== hdl/int_literal_parser.sv =====
// top level of the integer literal parser
`timescale 1ns / 1ps
// Parses one integer literal per frame of character beats.
// Input: one ASCII character per beat in s_axis_tdata, s_axis_tlast on the
// final character of the literal. Forms: optional '-', decimal digits or
// "0x" and hex digits, optional final 'l' or 'L' for 64-bit range.
// Output: one beat per literal on the master side, only for the last
// character; tdata holds the signed 64-bit value, tuser the status and the
// long flag.
// Throughput: one character per cycle while the result side is not stalled,
// set by the accumulator update (one shift-add per cycle in the back end).
// After the last character leaves the queue, its result passes the check
// stage register and then the output register, which drives m_axis_tvalid.
// Characters go through a small queue, so the front keeps taking beats while
// the result side holds a finished beat; when the receiver stalls the check
// stage and output register fill, the next last character waits at the
// queue head and the queue then drops s_axis_tready.
// Reset (async, active low) clears the queue and all literal state; the
// first character after reset starts a new literal.
module int_literal_parser #(
  parameter int unsigned QueueDepth = ilp_pkg::IlpQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ilp_pkg::CharW-1:0]     s_axis_tdata,  // [7:0] char_code
  input  logic                          s_axis_tlast,  // last_char
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ilp_pkg::OutDataW-1:0]  m_axis_tdata,  // [63:0] literal_value
  output logic [ilp_pkg::OutUserW-1:0]  m_axis_tuser   // [1:0] status, [2] long_form
);
  import ilp_pkg::*;

  logic q_full;
  logic q_push;
  op_t  q_op;
  logic head_valid;
  op_t  head_op;
  logic head_pop;
  logic rec_valid;
  rec_t rec;
  logic rec_ready;

  ilp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_op_o        (q_op)
  );

  ilp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_op_i    (q_op),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_op_o    (head_op),
    .pop_i        (head_pop)
  );

  logic exec_ready;

  ilp_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (head_valid),
    .op_i        (head_op),
    .op_ready_o  (exec_ready),
    .rec_valid_o (rec_valid),
    .rec_o       (rec),
    .rec_ready_i (rec_ready)
  );

  assign head_pop = head_valid && exec_ready;

  ilp_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (rec_valid),
    .rec_i         (rec),
    .rec_ready_o   (rec_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hdl/ilp_front.sv =====
// input side: takes character beats and classifies them into queue entries
`timescale 1ns / 1ps
module ilp_front (
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ilp_pkg::CharW-1:0]  s_axis_tdata,
  input  logic                       s_axis_tlast,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output ilp_pkg::op_t               q_op_o
);
  import ilp_pkg::*;

  logic [CharW-1:0] c;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_op_o.last  = s_axis_tlast;
    q_op_o.digit = 4'd0;
    q_op_o.kind  = OP_OTHER;
    if (s_axis_tlast && (c == CharLoL || c == CharUpL)) begin
      q_op_o.kind = OP_SUFFIX;
    end else if (c == CharMinus) begin
      q_op_o.kind = OP_MINUS;
    end else if (c == CharX) begin
      q_op_o.kind = OP_XCHAR;
    end else if (c inside {[CharZero:CharNine]}) begin
      q_op_o.kind  = OP_DEC_DIGIT;
      q_op_o.digit = 4'(c - CharZero);
    end else if (c inside {[CharUpA:CharUpF]}) begin
      q_op_o.kind  = OP_HEX_LETTER;
      q_op_o.digit = 4'(c - UpHexBias);
    end else if (c inside {[CharLoA:CharLoF]}) begin
      q_op_o.kind  = OP_HEX_LETTER;
      q_op_o.digit = 4'(c - LoHexBias);
    end
  end

endmodule

// ===== hdl/ilp_queue.sv =====
// short queue of classified characters between front and back
`timescale 1ns / 1ps
module ilp_queue #(
  parameter int unsigned Depth = ilp_pkg::IlpQueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ilp_pkg::op_t push_op_i,
  output logic         full_o,
  output logic         head_valid_o,
  output ilp_pkg::op_t head_op_o,
  input  logic         pop_i
);
  import ilp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_op_o    = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== hdl/ilp_exec.sv =====
// back side: literal state and digit accumulation, one per unstalled cycle
`timescale 1ns / 1ps
module ilp_exec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  ilp_pkg::op_t  op_i,
  output logic          op_ready_o,
  output logic          rec_valid_o,
  output ilp_pkg::rec_t rec_o,
  input  logic          rec_ready_i
);
  import ilp_pkg::*;

  logic [CountW-1:0] pos_q, pos_d, pos_a;
  logic              neg_q, neg_d, neg_a;
  logic              hex_q, hex_d, hex_a;
  logic [ValueW-1:0] acc_q, acc_d, acc_a;
  logic [CountW-1:0] dcnt_q, dcnt_d, dcnt_a;
  logic              ovf_q, ovf_d, ovf_a;
  logic              bad_q, bad_d, bad_a;

  logic              fire;
  logic [CountW-1:0] body_one;
  logic              digit_ok;
  logic [CountW-1:0] cap;
  logic [ValueW-1:0] acc_dec;
  logic [ValueW-1:0] acc_hex;

  assign op_ready_o  = !op_i.last || rec_ready_i;
  assign fire        = op_valid_i && op_ready_o;
  assign rec_valid_o = op_valid_i && op_i.last;

  assign body_one = CountW'(1) + CountW'(neg_q);
  assign digit_ok = (op_i.kind == OP_DEC_DIGIT) || (op_i.kind == OP_HEX_LETTER && hex_q);
  assign cap      = hex_q ? HexCap : DecCap;
  // times ten as two shifted copies plus the new digit
  assign acc_dec  = {acc_q[ValueW-4:0], 3'b000} + {acc_q[ValueW-2:0], 1'b0}
                    + ValueW'(op_i.digit);
  assign acc_hex  = {acc_q[ValueW-5:0], op_i.digit};

  always_comb begin
    pos_a  = pos_q;
    neg_a  = neg_q;
    hex_a  = hex_q;
    acc_a  = acc_q;
    dcnt_a = dcnt_q;
    ovf_a  = ovf_q;
    bad_a  = bad_q;
    if (op_i.kind != OP_SUFFIX) begin
      if (op_i.kind == OP_MINUS && pos_q == '0) begin
        neg_a = 1'b1;
      end else if (!hex_q && op_i.kind == OP_XCHAR && pos_q == body_one &&
                   dcnt_q == CountW'(1) && acc_q == '0) begin
        hex_a  = 1'b1;
        dcnt_a = '0;
      end else if (!digit_ok) begin
        bad_a = 1'b1;
      end else begin
        if (dcnt_q >= cap) begin
          ovf_a = 1'b1;
        end else begin
          acc_a = hex_q ? acc_hex : acc_dec;
        end
        if (dcnt_q != CountMax) begin
          dcnt_a = dcnt_q + CountW'(1);
        end
      end
      if (pos_q != CountMax) begin
        pos_a = pos_q + CountW'(1);
      end
    end
  end

  always_comb begin
    rec_o.negative  = neg_a;
    rec_o.hex       = hex_a;
    rec_o.magnitude = acc_a;
    rec_o.digits    = dcnt_a;
    rec_o.overflow  = ovf_a;
    rec_o.bad_char  = bad_a;
    rec_o.long_form = (op_i.kind == OP_SUFFIX);
  end

  always_comb begin
    pos_d  = pos_q;
    neg_d  = neg_q;
    hex_d  = hex_q;
    acc_d  = acc_q;
    dcnt_d = dcnt_q;
    ovf_d  = ovf_q;
    bad_d  = bad_q;
    if (fire) begin
      if (op_i.last) begin
        // literal done, start the next one from scratch
        pos_d  = '0;
        neg_d  = 1'b0;
        hex_d  = 1'b0;
        acc_d  = '0;
        dcnt_d = '0;
        ovf_d  = 1'b0;
        bad_d  = 1'b0;
      end else begin
        pos_d  = pos_a;
        neg_d  = neg_a;
        hex_d  = hex_a;
        acc_d  = acc_a;
        dcnt_d = dcnt_a;
        ovf_d  = ovf_a;
        bad_d  = bad_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      neg_q  <= 1'b0;
      hex_q  <= 1'b0;
      acc_q  <= '0;
      dcnt_q <= '0;
      ovf_q  <= 1'b0;
      bad_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      neg_q  <= neg_d;
      hex_q  <= hex_d;
      acc_q  <= acc_d;
      dcnt_q <= dcnt_d;
      ovf_q  <= ovf_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ===== hdl/ilp_finish.sv =====
// range checks, sign handling and the registered result beat
`timescale 1ns / 1ps
module ilp_finish (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rec_valid_i,
  input  ilp_pkg::rec_t                 rec_i,
  output logic                          rec_ready_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ilp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [ilp_pkg::OutUserW-1:0]  m_axis_tuser
);
  import ilp_pkg::*;

  logic              rec_valid_q;
  rec_t              rec_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [OutUserW-1:0] out_user_q, out_user_d;
  logic              advance;

  status_e           status;
  logic [ValueW-1:0] base_val;
  logic [ValueW-1:0] neg_val;
  logic [ValueW-1:0] max_mag;
  logic [CountW-1:0] limit;
  logic [ValueW-1:0] value;

  assign advance     = !out_valid_q || m_axis_tready;
  assign rec_ready_o = !rec_valid_q || advance;

  always_comb begin
    if (rec_q.hex) begin
      limit = rec_q.long_form ? HexLongLimit : HexShortLimit;
    end else begin
      limit = rec_q.long_form ? DecLongLimit : DecShortLimit;
    end
    if (rec_q.long_form) begin
      max_mag = rec_q.negative ? MaxNegLong : MaxPosLong;
    end else begin
      max_mag = rec_q.negative ? MaxNegShort : MaxPosShort;
    end
    // short hex is a 32-bit two's complement pattern
    if (rec_q.hex && !rec_q.long_form) begin
      base_val = {{32{rec_q.magnitude[31]}}, rec_q.magnitude[31:0]};
    end else begin
      base_val = rec_q.magnitude;
    end
    neg_val = ValueW'(0) - base_val;

    status = ST_VALID;
    if (rec_q.bad_char || rec_q.digits == '0) begin
      status = ST_MALFORMED;
    end else if (rec_q.overflow || rec_q.digits > limit ||
                 (!rec_q.hex && rec_q.magnitude > max_mag)) begin
      status = ST_RANGE;
    end

    if (status == ST_VALID) begin
      value = rec_q.negative ? neg_val : base_val;
    end else begin
      value = '0;
    end

    out_data_d = value;
    out_user_d = {rec_q.long_form, status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rec_ready_o) begin
        rec_valid_q <= rec_valid_i;
      end
      if (advance) begin
        out_valid_q <= rec_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ready_o && rec_valid_i) begin
      rec_q <= rec_i;
    end
    if (advance && rec_valid_q) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
